/* sv/pid_controller_deadband_macros.svh */
// -----------------------------------------------------------------------------
// PID controller assertion macros
// Concurrent assertion helpers used by the PID controller RTL.
// -----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_DEADBAND_MACROS_SVH
`define PID_CONTROLLER_DEADBAND_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define PIDD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
	else $error("PID controller assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define PIDD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
	else $error("PID controller assertion failed");
`else
`define PIDD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PIDD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* sv/pidd_pkg.sv */
// -----------------------------------------------------------------------------
// PID controller package
// Widths, register indexes, dead-band modes and stage structs.
// -----------------------------------------------------------------------------
`default_nettype none

package pidd_pkg;

	localparam int FRAC_BITS = 16;
	localparam int SUM_WIDTH = 48;
	localparam int DATA_W    = 32;
	localparam int ERR_W     = DATA_W + 1;
	localparam int LIMIT_W   = 31;
	localparam int MODE_W    = 2;
	localparam int CFG_IDX_W = 3;
	localparam int SUM_LO_W  = SUM_WIDTH / 2;
	localparam int SUM_HI_W  = SUM_WIDTH - SUM_LO_W;
	localparam int PROD_P_W  = 2 * DATA_W;
	localparam int PROD_D_W  = DATA_W + ERR_W;
	localparam int PROD_LO_W = DATA_W + SUM_LO_W + 1;
	localparam int PROD_HI_W = DATA_W + SUM_HI_W;
	localparam int ACC_W     = SUM_WIDTH + DATA_W + 2;

	localparam logic [LIMIT_W-1:0] DB_LIMIT_RESET = LIMIT_W'(983040);

	typedef enum logic [MODE_W-1:0] {
		DB_NONE     = 2'd0,
		DB_POSITION = 2'd1,
		DB_SPEED    = 2'd2
	} db_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P   = 3'd0,
		REG_GAIN_I   = 3'd1,
		REG_GAIN_D   = 3'd2,
		REG_SETPOINT = 3'd3,
		REG_DB_MODE  = 3'd4,
		REG_DB_LIMIT = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] gain_p;
		logic signed [DATA_W-1:0] gain_i;
		logic signed [DATA_W-1:0] gain_d;
		logic signed [DATA_W-1:0] setpoint;
		logic [MODE_W-1:0]        db_mode;
		logic [LIMIT_W-1:0]       db_limit;
	} cfg_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]    err;
		logic signed [ERR_W-1:0]     derr;
		logic signed [SUM_WIDTH-1:0] sum;
		logic                        clip;
	} front_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] drive;
		logic                     saturated;
	} result_t;

endpackage

`default_nettype wire

/* sv/pidd_intf.sv */
// -----------------------------------------------------------------------------
// PID controller channel interfaces
// Sample, result and configuration channels with valid/ready handshakes.
// -----------------------------------------------------------------------------
`default_nettype none

interface pidd_sample_if import pidd_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] measured;

	modport source (output valid, output measured, input ready);
	modport sink (input valid, input measured, output ready);
endinterface

interface pidd_result_if import pidd_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] drive;
	logic                     saturated;

	modport source (output valid, output drive, output saturated, input ready);
	modport sink (input valid, input drive, input saturated, output ready);
endinterface

interface pidd_cfg_if import pidd_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DATA_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* sv/pid_controller_deadband.sv */
// -----------------------------------------------------------------------------
// PID controller with dead band
// Positional Q16.16 PID controller with selectable dead band.
// -----------------------------------------------------------------------------
// Usage:
// Each request on the sample channel carries one measured value and produces
// exactly one request on the result channel with the drive value and a flag
// that is set when the error, the integral or the output was clipped.
// The cfg channel is always ready and writes the gains, the setpoint, the
// dead-band mode and the dead-band limit; write it only while the pipeline
// is empty.
// A sample passes from the accepting edge to result valid through five registers:
// input register, error and integral stage, product stage, accumulate stage and
// output register. Throughput is one sample per cycle while no result is stalled;
// the integral feedback closes in the error stage through adders only.
// When the receiver stalls a valid result, the whole pipeline holds and the
// sample channel drops ready until the result is taken.
// Reset clears the integral, the last error, the pipeline valid bits and the
// configuration registers to their defaults.
// -----------------------------------------------------------------------------
`default_nettype none

`include "pid_controller_deadband_macros.svh"

module pid_controller_deadband import pidd_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	pidd_sample_if.sink    sample,
	pidd_result_if.source  result,
	pidd_cfg_if.sink       cfg
);

	cfg_t cfg_q;

	logic adv;
	logic vld_s1;
	logic vld_s2;
	logic vld_s3;
	logic vld_s4;
	logic out_vld_q;

	logic signed [DATA_W-1:0] measured_s1;
	front_t                   front_s2;
	result_t                  res;
	result_t                  out_q;

	assign adv          = !out_vld_q || result.ready;
	assign sample.ready = adv;
	assign cfg.ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p   <= '0;
			cfg_q.gain_i   <= '0;
			cfg_q.gain_d   <= '0;
			cfg_q.setpoint <= '0;
			cfg_q.db_mode  <= DB_NONE;
			cfg_q.db_limit <= DB_LIMIT_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_GAIN_P:   cfg_q.gain_p   <= cfg.data;
				REG_GAIN_I:   cfg_q.gain_i   <= cfg.data;
				REG_GAIN_D:   cfg_q.gain_d   <= cfg.data;
				REG_SETPOINT: cfg_q.setpoint <= cfg.data;
				REG_DB_MODE:  cfg_q.db_mode  <= cfg.data[MODE_W-1:0];
				REG_DB_LIMIT: cfg_q.db_limit <= cfg.data[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1    <= sample.valid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			out_vld_q <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			measured_s1 <= sample.measured;
			out_q       <= res;
		end
	end

	pidd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.upd         (vld_s1 && adv),
		.measured_s1 (measured_s1),
		.cfg         (cfg_q),
		.front_s2    (front_s2)
	);

	pidd_mac u_mac (
		.clk      (clk),
		.adv      (adv),
		.cfg      (cfg_q),
		.front_s2 (front_s2),
		.res      (res)
	);

	assign result.valid     = out_vld_q;
	assign result.drive     = out_q.drive;
	assign result.saturated = out_q.saturated;

	`PIDD_ASSERT_IMP(a_stall_blocks_input, clk, arst_n, out_vld_q && !result.ready, !sample.ready)
	`PIDD_ASSERT_NXT(a_accept_enters_pipe, clk, arst_n, sample.valid && sample.ready, vld_s1)
	`PIDD_ASSERT_NXT(a_last_stage_to_out, clk, arst_n, vld_s4 && adv, out_vld_q)

endmodule

`default_nettype wire

/* sv/pidd_front.sv */
// -----------------------------------------------------------------------------
// PID controller error stage
// Forms the error, applies the dead band and updates the saturating integral.
// -----------------------------------------------------------------------------
`default_nettype none

module pidd_front import pidd_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     adv,
	input  wire logic                     upd,
	input  wire logic signed [DATA_W-1:0] measured_s1,
	input  wire cfg_t                     cfg,
	output front_t                        front_s2
);

	localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
	localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};
	localparam logic signed [DATA_W-1:0]    ERR_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0]    ERR_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	logic signed [DATA_W-1:0]    last_error_q;
	logic signed [SUM_WIDTH-1:0] error_sum_q;

	logic signed [ERR_W-1:0]       diff;
	logic [ERR_W-1:0]              mag;
	logic                          err_clip;
	logic signed [DATA_W-1:0]      err_sat;
	logic signed [DATA_W-1:0]      err_eff;
	logic signed [SUM_WIDTH-1:0]   sum_base;
	logic                          twice;
	logic signed [SUM_WIDTH+1:0]   inc;
	logic signed [SUM_WIDTH+1:0]   sum_wide;
	logic                          sum_ovf;
	logic signed [SUM_WIDTH-1:0]   sum_next;
	logic signed [ERR_W-1:0]       derr;

	always_comb begin
		diff     = {cfg.setpoint[DATA_W-1], cfg.setpoint} - {measured_s1[DATA_W-1], measured_s1};
		mag      = diff[ERR_W-1] ? (~diff + ERR_W'(1)) : diff;
		err_clip = diff[ERR_W-1] ^ diff[DATA_W-1];
		if (err_clip) begin
			err_sat = diff[ERR_W-1] ? ERR_MIN : ERR_MAX;
		end else begin
			err_sat = diff[DATA_W-1:0];
		end

		err_eff  = err_sat;
		sum_base = error_sum_q;
		twice    = 1'b0;
		unique case (cfg.db_mode)
			DB_POSITION: begin
				if (mag <= {2'b00, cfg.db_limit}) begin
					err_eff  = '0;
					sum_base = '0;
				end
			end
			DB_SPEED: begin
				if (mag < {2'b00, cfg.db_limit}) begin
					err_eff = '0;
				end
				twice = 1'b1;
			end
			default: begin
			end
		endcase

		if (twice) begin
			inc = {{(SUM_WIDTH+1-DATA_W){err_eff[DATA_W-1]}}, err_eff, 1'b0};
		end else begin
			inc = {{(SUM_WIDTH+2-DATA_W){err_eff[DATA_W-1]}}, err_eff};
		end
		sum_wide = {{2{sum_base[SUM_WIDTH-1]}}, sum_base} + inc;
		sum_ovf  = !((&sum_wide[SUM_WIDTH+1:SUM_WIDTH-1]) ||
			!(|sum_wide[SUM_WIDTH+1:SUM_WIDTH-1]));
		if (sum_ovf) begin
			sum_next = sum_wide[SUM_WIDTH+1] ? SUM_MIN : SUM_MAX;
		end else begin
			sum_next = sum_wide[SUM_WIDTH-1:0];
		end

		derr = {err_eff[DATA_W-1], err_eff} - {last_error_q[DATA_W-1], last_error_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_error_q <= '0;
			error_sum_q  <= '0;
		end else if (upd) begin
			last_error_q <= err_eff;
			error_sum_q  <= sum_next;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			front_s2.err  <= err_eff;
			front_s2.derr <= derr;
			front_s2.sum  <= sum_next;
			front_s2.clip <= err_clip | sum_ovf;
		end
	end

endmodule

`default_nettype wire

/* sv/pidd_mac.sv */
// -----------------------------------------------------------------------------
// PID controller multiply-accumulate
// Gain products, full-precision sum, fraction shift and output saturation.
// -----------------------------------------------------------------------------
`default_nettype none

module pidd_mac import pidd_pkg::*; (
	input  wire logic   clk,
	input  wire logic   adv,
	input  wire cfg_t   cfg,
	input  wire front_t front_s2,
	output result_t     res
);

	localparam int SHIFT_W = ACC_W - FRAC_BITS;
	localparam logic signed [DATA_W-1:0] OUT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] OUT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	logic signed [DATA_W-1:0]   gain_p;
	logic signed [DATA_W-1:0]   gain_i;
	logic signed [DATA_W-1:0]   gain_d;
	logic signed [DATA_W-1:0]   err;
	logic signed [ERR_W-1:0]    derr;
	logic signed [SUM_LO_W:0]   sum_lo;
	logic signed [SUM_HI_W-1:0] sum_hi;

	logic signed [PROD_P_W-1:0]  prod_p_s3;
	logic signed [PROD_D_W-1:0]  prod_d_s3;
	logic signed [PROD_LO_W-1:0] prod_lo_s3;
	logic signed [PROD_HI_W-1:0] prod_hi_s3;
	logic                        clip_s3;

	logic signed [ACC_W-1:0] acc_s4;
	logic                    clip_s4;

	logic [SHIFT_W-1:0] shifted;
	logic               fits;

	assign gain_p = cfg.gain_p;
	assign gain_i = cfg.gain_i;
	assign gain_d = cfg.gain_d;
	assign err    = front_s2.err;
	assign derr   = front_s2.derr;
	assign sum_lo = {1'b0, front_s2.sum[SUM_LO_W-1:0]};
	assign sum_hi = front_s2.sum[SUM_WIDTH-1:SUM_LO_W];

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_p_s3  <= gain_p * err;
			prod_d_s3  <= gain_d * derr;
			prod_lo_s3 <= gain_i * sum_lo;
			prod_hi_s3 <= gain_i * sum_hi;
			clip_s3    <= front_s2.clip;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			acc_s4 <= ACC_W'(prod_p_s3) + ACC_W'(prod_d_s3) + ACC_W'(prod_lo_s3) +
				(ACC_W'(prod_hi_s3) <<< SUM_LO_W);
			clip_s4 <= clip_s3;
		end
	end

	always_comb begin
		shifted = acc_s4[ACC_W-1:FRAC_BITS];
		fits    = (&shifted[SHIFT_W-1:DATA_W-1]) || !(|shifted[SHIFT_W-1:DATA_W-1]);
		if (fits) begin
			res.drive = shifted[DATA_W-1:0];
		end else begin
			res.drive = acc_s4[ACC_W-1] ? OUT_MIN : OUT_MAX;
		end
		res.saturated = clip_s4 | ~fits;
	end

endmodule

`default_nettype wire

/* verif/pid_drive_checker.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// PID controller drive checker
// Watches the configuration, sample and result channels. It keeps its own copy
// of the gains, the dead band, the last error and the integral, works out the
// drive and clip flag for every accepted sample, and compares each accepted
// result with the oldest outstanding prediction.
// -----------------------------------------------------------------------------

module pid_drive_checker import pidd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	pidd_sample_if sample,
	pidd_result_if result,
	pidd_cfg_if    cfg,
	output int     mismatches,
	output int     outstanding
);

	localparam int PROD_W = 128;

	localparam logic signed [DATA_W+1:0] DIFF_TOP = {3'b000, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W+1:0] DIFF_BOT = {3'b111, {(DATA_W-1){1'b0}}};
	localparam logic signed [SUM_WIDTH:0] SUM_TOP = {2'b00, {(SUM_WIDTH-1){1'b1}}};
	localparam logic signed [SUM_WIDTH:0] SUM_BOT = {2'b11, {(SUM_WIDTH-1){1'b0}}};
	localparam logic signed [PROD_W-1:0] OUT_TOP =
		{{(PROD_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
	localparam logic signed [PROD_W-1:0] OUT_BOT =
		{{(PROD_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

	logic signed [DATA_W-1:0]    k_p;
	logic signed [DATA_W-1:0]    k_i;
	logic signed [DATA_W-1:0]    k_d;
	logic signed [DATA_W-1:0]    target;
	logic [MODE_W-1:0]           band_mode;
	logic [LIMIT_W-1:0]          band_limit;
	logic signed [DATA_W-1:0]    prev_err;
	logic signed [SUM_WIDTH-1:0] integ;
	result_t                     expected_drives[$];
	result_t                     oldest;

	initial mismatches = 0;

	// Saturating integral update; the top bit of the return value is the clip flag.
	function automatic logic [SUM_WIDTH:0] integrate(
		input logic signed [SUM_WIDTH-1:0] acc_in,
		input logic signed [DATA_W-1:0]    err
	);
		logic signed [SUM_WIDTH:0] wide;
		wide = acc_in + err;
		if (wide > SUM_TOP) begin
			return {1'b1, SUM_TOP[SUM_WIDTH-1:0]};
		end
		if (wide < SUM_BOT) begin
			return {1'b1, SUM_BOT[SUM_WIDTH-1:0]};
		end
		return {1'b0, wide[SUM_WIDTH-1:0]};
	endfunction

	function automatic result_t pid_law(input logic signed [DATA_W-1:0] meas);
		logic signed [DATA_W+1:0] diff;
		logic [DATA_W+1:0]        mag;
		logic signed [DATA_W-1:0] err;
		logic signed [DATA_W:0]   derr;
		logic [SUM_WIDTH:0]       upd;
		logic signed [PROD_W-1:0] total;
		logic                     clip;
		result_t                  r;
		clip = 1'b0;
		diff = target - meas;
		mag = (diff < 0) ? -diff : diff;
		if (diff > DIFF_TOP) begin
			err = DIFF_TOP[DATA_W-1:0];
			clip = 1'b1;
		end else if (diff < DIFF_BOT) begin
			err = DIFF_BOT[DATA_W-1:0];
			clip = 1'b1;
		end else begin
			err = diff[DATA_W-1:0];
		end
		if (band_mode == DB_POSITION) begin
			if (mag <= band_limit) begin
				err = '0;
				integ = '0;
			end
		end else if (band_mode == DB_SPEED) begin
			// Speed mode accumulates the error twice per sample.
			if (mag < band_limit) begin
				err = '0;
			end
			upd = integrate(integ, err);
			clip |= upd[SUM_WIDTH];
			integ = upd[SUM_WIDTH-1:0];
		end
		upd = integrate(integ, err);
		clip |= upd[SUM_WIDTH];
		integ = upd[SUM_WIDTH-1:0];
		derr = err - prev_err;
		total = k_p * err + k_i * integ + k_d * derr;
		total = total >>> FRAC_BITS;
		prev_err = err;
		if (total > OUT_TOP) begin
			r.drive = OUT_TOP[DATA_W-1:0];
			clip = 1'b1;
		end else if (total < OUT_BOT) begin
			r.drive = OUT_BOT[DATA_W-1:0];
			clip = 1'b1;
		end else begin
			r.drive = total[DATA_W-1:0];
		end
		r.saturated = clip;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_p = '0;
			k_i = '0;
			k_d = '0;
			target = '0;
			band_mode = DB_NONE;
			band_limit = DB_LIMIT_RESET;
			prev_err = '0;
			integ = '0;
			expected_drives.delete();
			outstanding <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_GAIN_P: k_p = cfg.data;
					REG_GAIN_I: k_i = cfg.data;
					REG_GAIN_D: k_d = cfg.data;
					REG_SETPOINT: target = cfg.data;
					REG_DB_MODE: band_mode = cfg.data[MODE_W-1:0];
					REG_DB_LIMIT: band_limit = cfg.data[LIMIT_W-1:0];
					default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				if (expected_drives.size() == 0) begin
					$error("drive: no request outstanding, got %0d", result.drive);
					mismatches++;
				end else begin
					oldest = expected_drives.pop_front();
					if (oldest.drive !== result.drive) begin
						$error("drive: expected %0d, got %0d", oldest.drive, result.drive);
						mismatches++;
					end
					if (oldest.saturated !== result.saturated) begin
						$error("saturated: expected %0b, got %0b", oldest.saturated,
							result.saturated);
						mismatches++;
					end
				end
			end
			if (sample.valid && sample.ready) begin
				expected_drives.push_back(pid_law(sample.measured));
			end
			outstanding <= expected_drives.size();
		end
	end

endmodule

/* verif/tb_pid_controller_deadband.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// PID controller with dead band testbench
// Drives directed samples at the field and dead-band edges, a hard integral
// windup in both directions, and randomly configured phases of random samples,
// with random gaps on the sample side and random stalls on the result side.
// The checker beside the block predicts and compares every result.
// -----------------------------------------------------------------------------

module tb_pid_controller_deadband;
	import pidd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int WINDUP_ITEMS = 40;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 90;
	localparam logic [MODE_W-1:0] DB_RESERVED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam logic [DATA_W-1:0] POS_MAX = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] NEG_MAX = 32'h8000_0000;
	localparam logic [DATA_W-1:0] UNITY = 32'h0001_0000;

	logic clk;
	logic arst_n;
	int   chk_mismatches;
	int   chk_outstanding;
	bit   calm = 1'b0;
	int unsigned cycles = 0;
	logic signed [DATA_W-1:0] cur_setpoint;
	logic [LIMIT_W-1:0]       cur_limit;

	pidd_sample_if sample_ch ();
	pidd_result_if result_ch ();
	pidd_cfg_if    cfg_ch ();

	pid_controller_deadband u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	pid_drive_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample      (sample_ch),
		.result      (result_ch),
		.cfg         (cfg_ch),
		.mismatches  (chk_mismatches),
		.outstanding (chk_outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_pid_controller_deadband: errors");
			$finish;
		end
	end

	initial begin
		int hold;
		result_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			hold = calm ? 0 : $urandom_range(0, 11);
			if (hold > 0) begin
				result_ch.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (!result_ch.valid) @(posedge clk);
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
	endtask

	task automatic configure(
		input logic [DATA_W-1:0] gp,
		input logic [DATA_W-1:0] gi,
		input logic [DATA_W-1:0] gd,
		input logic [DATA_W-1:0] sp,
		input logic [DATA_W-1:0] mode_word,
		input logic [DATA_W-1:0] limit_word
	);
		write_reg(REG_GAIN_P, gp);
		write_reg(REG_GAIN_I, gi);
		if ($urandom_range(0, 3) == 0) begin
			write_reg(REG_SPARE_LO, $urandom);
		end
		write_reg(REG_GAIN_D, gd);
		write_reg(REG_SETPOINT, sp);
		write_reg(REG_DB_MODE, mode_word);
		if ($urandom_range(0, 3) == 0) begin
			write_reg(REG_SPARE_HI, $urandom);
		end
		write_reg(REG_DB_LIMIT, limit_word);
		cfg_ch.valid <= 1'b0;
		cur_setpoint = sp;
		cur_limit = limit_word[LIMIT_W-1:0];
	endtask

	task automatic send_sample(input logic signed [DATA_W-1:0] value);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			sample_ch.measured <= $urandom;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.measured <= value;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
	endtask

	task automatic wait_drained();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (chk_outstanding != 0) @(posedge clk);
	endtask

	function automatic logic [DATA_W-1:0] pick_gain();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return $urandom_range(0, 2**19) - 2**18;
			5: return $urandom;
			6: return POS_MAX;
			7: return NEG_MAX;
			8: return '0;
			default: return $urandom_range(0, 1) ? UNITY * $urandom_range(1, 4)
				: -(UNITY * $urandom_range(1, 4));
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_setpoint();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return $urandom_range(0, 2**23) - 2**22;
			6: return $urandom;
			7: return POS_MAX;
			8: return NEG_MAX;
			default: return '0;
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_limit_word();
		logic [LIMIT_W-1:0] lim;
		case ($urandom_range(0, 9))
			0: lim = '0;
			1: lim = DB_LIMIT_RESET;
			2: lim = LIMIT_W'(19661);
			3: lim = '1;
			4, 5, 6: lim = LIMIT_W'($urandom_range(0, 2**21));
			default: lim = LIMIT_W'($urandom);
		endcase
		return {$urandom_range(0, 1) == 1, lim};
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_measured();
		logic [DATA_W-1:0] lim;
		logic [DATA_W-1:0] span;
		lim = {1'b0, cur_limit};
		span = (cur_limit > 2**20) ? 2**20 : lim + 2;
		case ($urandom_range(0, 9))
			0: return POS_MAX;
			1: return NEG_MAX;
			2: return $urandom_range(0, 1) ? cur_setpoint + lim : cur_setpoint - lim;
			3: return $urandom_range(0, 1) ? cur_setpoint + lim + 1 : cur_setpoint - lim - 1;
			4: return $urandom_range(0, 1) ? cur_setpoint + lim - 1 : cur_setpoint - lim + 1;
			5, 6: return cur_setpoint + $urandom_range(0, 2 * span) - span;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		arst_n <= 1'b0;
		sample_ch.valid <= 1'b0;
		sample_ch.measured <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_GAIN_P;
		cfg_ch.data <= '0;
		cur_setpoint = '0;
		cur_limit = DB_LIMIT_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset configuration: zero gains, only the error clip shows.
		send_sample(POS_MAX);
		send_sample(NEG_MAX);
		wait_drained();

		configure(UNITY, 32'h0000_0100, -UNITY, '0, 32'(DB_NONE), 32'(DB_LIMIT_RESET));
		send_sample('0);
		send_sample(32'sd1);
		send_sample(-32'sd1);
		send_sample(POS_MAX);
		send_sample(NEG_MAX);
		send_sample(32'h4000_0000);
		wait_drained();

		configure(UNITY, UNITY, UNITY, 32'h0005_0000, 32'(DB_POSITION), 32'd983040);
		send_sample(32'h0005_0000 + 32'd983040);
		send_sample(32'h0005_0000 - 32'd983040);
		send_sample(32'h0005_0000 + 32'd983041);
		send_sample(32'h0005_0000 - 32'd983041);
		send_sample(32'h0005_0000);
		wait_drained();

		configure(UNITY, UNITY, UNITY, '0, 32'(DB_SPEED), 32'd19661);
		send_sample(32'sd19661);
		send_sample(-32'sd19660);
		send_sample(32'sd19660);
		send_sample(-32'sd19661);
		wait_drained();

		configure(POS_MAX, NEG_MAX, POS_MAX, NEG_MAX, {30'h3FFF_FFFF, DB_RESERVED}, '1);
		send_sample(POS_MAX);
		send_sample(NEG_MAX);
		send_sample('0);
		wait_drained();

		// Wind the integral up hard in both directions; the position dead band clears it between.
		calm = 1'b1;
		configure('0, 32'd1, '0, POS_MAX, 32'(DB_SPEED), '0);
		repeat (WINDUP_ITEMS) send_sample(NEG_MAX);
		wait_drained();
		configure('0, 32'd1, '0, POS_MAX, 32'(DB_POSITION), '0);
		send_sample(POS_MAX);
		wait_drained();
		configure('0, 32'd1, '0, NEG_MAX, 32'(DB_SPEED), '0);
		repeat (WINDUP_ITEMS) send_sample(POS_MAX);
		wait_drained();

		for (int ph = 0; ph < PHASES; ph++) begin
			calm = ($urandom_range(0, 3) == 0);
			configure(pick_gain(), pick_gain(), pick_gain(), pick_setpoint(),
				($urandom & ~32'(DB_RESERVED)) | 32'($urandom_range(DB_NONE, DB_RESERVED)),
				pick_limit_word());
			repeat (PHASE_ITEMS) send_sample(pick_measured());
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (chk_mismatches == 0 && chk_outstanding == 0) begin
			$display("tb_pid_controller_deadband: clean");
		end else begin
			$display("tb_pid_controller_deadband: errors");
		end
		$finish;
	end

endmodule
